@@ hdl/cau_pkg.sv @@
// shared types, constants and saturation helpers for the complex arithmetic unit
// used by cau_div_pipe and complex_arith_unit; no dependencies
`default_nettype none
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = 32;
  localparam int PROD_W = 2 * W;
  localparam int REM_W = PROD_W + FRAC_BITS;
  localparam int CMP_W = PROD_W + W;
  localparam int TOL_W = 17;
  localparam int DIV_STEPS = W;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [W-1:0]     re;
    logic [W-1:0]     im;
    logic             eq;
    logic             ovf;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
    logic             big_re;
    logic             big_im;
    logic [PROD_W-1:0] den;
    logic [REM_W-1:0] rem_re;
    logic [REM_W-1:0] rem_im;
    logic [W-1:0]     q_re;
    logic [W-1:0]     q_im;
  } stage_t;

  // sign/magnitude to saturated two's complement, overflow flag on top
  function automatic logic [W:0] sat_mag(input logic neg, input logic [PROD_W:0] mag);
    logic [PROD_W:0] lim;
    logic [PROD_W:0] m;
    logic o;
    lim = neg ? ((PROD_W+1)'(1) << (W-1)) : (((PROD_W+1)'(1) << (W-1)) - (PROD_W+1)'(1));
    o = mag > lim;
    m = o ? lim : mag;
    if (neg) m = (PROD_W+1)'(0) - m;
    return {o, m[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_s33(input logic signed [W:0] v);
    logic [PROD_W:0] mag;
    mag = v[W] ? (PROD_W+1)'(-v) : (PROD_W+1)'(v);
    return sat_mag(v[W], mag);
  endfunction

endpackage
`default_nettype wire

@@ hdl/cau_div_pipe.sv @@
// restoring divider pipeline, one quotient bit per stage for both result parts
// depends on cau_pkg
`default_nettype none
module cau_div_pipe (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire cau_pkg::stage_t in_stage,
  output cau_pkg::stage_t      out_stage
);

  cau_pkg::stage_t pipe [0:cau_pkg::DIV_STEPS];

  assign pipe[0] = in_stage;
  assign out_stage = pipe[cau_pkg::DIV_STEPS];

  for (genvar k = 0; k < cau_pkg::DIV_STEPS; k++) begin : g_step
    localparam int SH = cau_pkg::DIV_STEPS - 1 - k;
    logic [cau_pkg::CMP_W-1:0] dsh;
    logic [cau_pkg::CMP_W-1:0] xr;
    logic [cau_pkg::CMP_W-1:0] xi;
    logic gr;
    logic gi;
    cau_pkg::stage_t nxt;

    always_comb begin
      dsh = cau_pkg::CMP_W'(pipe[k].den) << SH;
      xr = cau_pkg::CMP_W'(pipe[k].rem_re);
      xi = cau_pkg::CMP_W'(pipe[k].rem_im);
      gr = xr >= dsh;
      gi = xi >= dsh;
      nxt = pipe[k];
      if (gr) nxt.rem_re = cau_pkg::REM_W'(xr - dsh);
      if (gi) nxt.rem_im = cau_pkg::REM_W'(xi - dsh);
      nxt.q_re = {pipe[k].q_re[cau_pkg::W-2:0], gr};
      nxt.q_im = {pipe[k].q_im[cau_pkg::W-2:0], gi};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].valid <= 1'b0;
      end else if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/complex_arith_unit.sv @@
// complex arithmetic unit top level: operand pipeline, products, sums, divider, output
// depends on cau_pkg and cau_div_pipe
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata a_re,a_im,b_re,b_im; s_tuser opcode
// m_       out  m_tvalid/m_tready  m_tdata res_re,res_im; m_tuser is_equal,overflow,divide_by_zero
// cfg_     in   cfg_we             cfg_wdata equal_tolerance
//
// one beat per cycle sustained while the output is not stalled; every opcode goes through the
// 32-stage restoring divider, which all beats pass through to keep order
// synchronous reset clears valid bits and sets the tolerance to one
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
`default_nettype none
module complex_arith_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [127:0]  s_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [2:0]    s_tuser,   // opcode
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [63:0]        m_tdata,   // res_re, res_im
  output logic [2:0]         m_tuser,   // is_equal, overflow, divide_by_zero
  input  wire logic          cfg_we,
  input  wire logic [16:0]   cfg_wdata
);

  localparam int W = cau_pkg::W;
  localparam int PW = cau_pkg::PROD_W;

  logic en;
  logic [cau_pkg::TOL_W-1:0] tol;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= cau_pkg::TOL_W'(1);
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // stage 1: operands
  logic v1;
  cau_pkg::op_t op1;
  logic signed [W-1:0] ar, ai, br, bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      op1 <= cau_pkg::op_t'(s_tuser);
      ar <= s_tdata[31:0];
      ai <= s_tdata[63:32];
      br <= s_tdata[95:64];
      bi <= s_tdata[127:96];
    end
  end

  // stage 2: products, simple ops
  cau_pkg::stage_t s2, s2_next;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [PW-1:0] q_r, q_i;
  logic [W:0] sr, si;
  logic signed [W:0] dr, di;
  logic [W:0] ur, ui;

  always_comb begin
    s2_next = '0;
    s2_next.valid = v1;
    s2_next.op = op1;
    dr = 33'(ar) - 33'(br);
    di = 33'(ai) - 33'(bi);
    ur = dr[W] ? 33'(-dr) : 33'(dr);
    ui = di[W] ? 33'(-di) : 33'(di);
    sr = '0;
    si = '0;
    case (op1)
      cau_pkg::OP_ADD: begin
        sr = cau_pkg::sat_s33(33'(ar) + 33'(br));
        si = cau_pkg::sat_s33(33'(ai) + 33'(bi));
      end
      cau_pkg::OP_SUB: begin
        sr = cau_pkg::sat_s33(dr);
        si = cau_pkg::sat_s33(di);
      end
      cau_pkg::OP_DIV: s2_next.dz = (br == '0) && (bi == '0);
      cau_pkg::OP_CMP: s2_next.eq = (ur < 33'(tol)) && (ui < 33'(tol));
      default: ;
    endcase
    s2_next.re = sr[W-1:0];
    s2_next.im = si[W-1:0];
    s2_next.ovf = sr[W] | si[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2 <= s2_next;
    end
    if (en) begin
      p_rr <= ar * br;
      p_ii <= ai * bi;
      p_ri <= ar * bi;
      p_ir <= ai * br;
      q_r <= PW'(br * br);
      q_i <= PW'(bi * bi);
    end
  end

  // stage 3: sums as sign and magnitude
  cau_pkg::stage_t s3, s3_next;
  logic [PW-1:0] m_re, m_im, m_re_next, m_im_next;
  logic n_re_next, n_im_next;
  logic signed [PW:0] x_re, x_im;

  always_comb begin
    if (s2.op == cau_pkg::OP_DIV) begin
      x_re = 65'(p_rr) + 65'(p_ii);
      x_im = 65'(p_ir) - 65'(p_ri);
    end else begin
      x_re = 65'(p_rr) - 65'(p_ii);
      x_im = 65'(p_ri) + 65'(p_ir);
    end
    n_re_next = x_re[PW];
    n_im_next = x_im[PW];
    m_re_next = n_re_next ? PW'(-x_re) : PW'(x_re);
    m_im_next = n_im_next ? PW'(-x_im) : PW'(x_im);
    s3_next = s2;
    s3_next.neg_re = n_re_next;
    s3_next.neg_im = n_im_next;
    s3_next.den = q_r + q_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (en) begin
      s3 <= s3_next;
    end
    if (en) begin
      m_re <= m_re_next;
      m_im <= m_im_next;
    end
  end

  // stage 4: multiply rounding, divider set-up
  cau_pkg::stage_t s4, s4_next;
  logic [PW:0] r_re, r_im;
  logic [W:0] t_re, t_im;
  logic [cau_pkg::CMP_W-1:0] dlim;

  always_comb begin
    s4_next = s3;
    r_re = (65'(m_re) + (65'(1) << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
    r_im = (65'(m_im) + (65'(1) << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
    t_re = cau_pkg::sat_mag(s3.neg_re, r_re);
    t_im = cau_pkg::sat_mag(s3.neg_im, r_im);
    dlim = {s3.den, W'(0)};
    s4_next.rem_re = {m_re, cau_pkg::FRAC_BITS'(0)};
    s4_next.rem_im = {m_im, cau_pkg::FRAC_BITS'(0)};
    s4_next.big_re = cau_pkg::CMP_W'({m_re, cau_pkg::FRAC_BITS'(0)}) >= dlim;
    s4_next.big_im = cau_pkg::CMP_W'({m_im, cau_pkg::FRAC_BITS'(0)}) >= dlim;
    s4_next.q_re = '0;
    s4_next.q_im = '0;
    if (s3.op == cau_pkg::OP_MUL) begin
      s4_next.re = t_re[W-1:0];
      s4_next.im = t_im[W-1:0];
      s4_next.ovf = t_re[W] | t_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (en) begin
      s4 <= s4_next;
    end
  end

  cau_pkg::stage_t sd;

  cau_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_stage (s4),
    .out_stage(sd)
  );

  // output: divide saturation
  logic [W:0] f_re, f_im;
  logic [W-1:0] o_re, o_im;
  logic o_ovf;

  always_comb begin
    f_re = cau_pkg::sat_mag(sd.neg_re, sd.big_re ? ~(PW+1)'(0) : (PW+1)'(sd.q_re));
    f_im = cau_pkg::sat_mag(sd.neg_im, sd.big_im ? ~(PW+1)'(0) : (PW+1)'(sd.q_im));
    o_re = sd.re;
    o_im = sd.im;
    o_ovf = sd.ovf;
    if (sd.op == cau_pkg::OP_DIV && !sd.dz) begin
      o_re = f_re[W-1:0];
      o_im = f_im[W-1:0];
      o_ovf = f_re[W] | f_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sd.valid;
    end
    if (en) begin
      m_tdata <= {o_im, o_re};
      m_tuser <= {sd.dz, o_ovf, sd.eq};
    end
  end

endmodule
`default_nettype wire
